// ===== src/assert_macros.svh =====
// Assertion macros shared by the frame receiver RTL.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ACFR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("acfr: assertion failed");

// Check that a trigger is followed by a condition in the next cycle.
`define ACFR_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("acfr: sequence assertion failed");

`endif

// ===== src/acfr_pkg.sv =====
// Package for the addressed command frame receiver: beat types, codes, constants.
// No dependencies.
package acfr_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [5:0] BROADCAST = 6'h3F;
    localparam int         FRAME_LEN = 6;
    localparam int         MOD_STEPS = 6;

    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_GAP_TIMEOUT    = 2'd1;

    localparam logic [7:0] GAP_TIMEOUT_RESET = 8'd2;

    typedef enum logic [1:0] {
        MODE_ADDRESS      = 2'b00,
        MODE_SKIP_ADDRESS = 2'b01,
        MODE_RESIDUE      = 2'b10,
        MODE_ALWAYS       = 2'b11
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CHECK,
        ST_MOD,
        ST_EMIT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t    op;
        logic [8:0] a;
        logic [8:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [8:0] value;
        logic       carry;
    } alu_rsp_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic       background;
        logic [6:0] animation_id;
        logic [7:0] param_one;
        logic [7:0] param_two;
        logic [7:0] param_three;
    } out_t;

endpackage

// ===== src/acfr_alu.sv =====
// Shared 9-bit add/subtract unit used for the checksum sum and the modulo steps.
// Depends on acfr_pkg.
module acfr_alu
(
    input  acfr_pkg::alu_req_t req,
    output acfr_pkg::alu_rsp_t rsp
);

    logic [9:0] result;

    always_comb
    begin
        case (req.op)
            acfr_pkg::ALU_ADD: result = {1'b0, req.a} + {1'b0, req.b};
            acfr_pkg::ALU_SUB: result = {1'b0, req.a} - {1'b0, req.b};
            default:           result = '0;
        endcase
        rsp.value = result[8:0];
        rsp.carry = result[9];
    end

endmodule

// ===== src/acfr_frame_buf.sv =====
// Six-byte frame store with one write port and one registered read port.
// Depends on acfr_pkg.
module acfr_frame_buf
(
    input  logic       clk,
    input  logic       wr_en,
    input  logic [2:0] wr_addr,
    input  logic [7:0] wr_data,
    input  logic [2:0] rd_addr,
    output logic [7:0] rd_data
);

    logic [7:0] mem [acfr_pkg::FRAME_LEN];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr < 3'(acfr_pkg::FRAME_LEN)))
        begin
            mem[wr_addr] <= wr_data;
        end
        // Hold the last word read when the address runs past the end
        if (rd_addr < 3'(acfr_pkg::FRAME_LEN))
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/addressed_command_frame_receiver.sv =====
// Addressed command frame receiver, top level. Beats are taken only in idle.
// A checksum byte runs the sum pass, the check and, unless the check drops the frame,
// the emit, with 6 modulo steps before the emit in modulo mode; the emit of a result
// waits while an earlier result beat is held. Depends on acfr_pkg, acfr_alu,
// acfr_frame_buf and assert_macros.svh. Asynchronous active-low reset: idle,
// counters and last session cleared, device address 0, gap timeout 2 ticks.
`include "assert_macros.svh"

module addressed_command_frame_receiver
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  acfr_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output acfr_pkg::out_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);

    // Control state
    acfr_pkg::state_t state_reg, state_next;
    logic             receiving_reg, receiving_next;
    logic [2:0]       byte_count_reg, byte_count_next;
    logic [7:0]       gap_reg, gap_next;
    logic [7:0]       last_session_reg, last_session_next;
    logic [5:0]       dev_addr_reg;
    logic [7:0]       gap_timeout_reg;
    logic [2:0]       cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers
    logic [7:0]       checksum_reg, checksum_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       session_reg, session_next;
    logic [7:0]       target_reg, target_next;
    logic [7:0]       command_reg, command_next;
    logic [7:0]       p1_reg, p1_next;
    logic [7:0]       p2_reg, p2_next;
    logic [7:0]       p3_reg, p3_next;
    logic [5:0]       rem_reg, rem_next;
    logic             pass_reg, pass_next;
    acfr_pkg::out_t   out_reg, out_next;

    // Buffer and shared unit hookup
    logic             buf_wr_en;
    logic [7:0]       buf_rd_data;
    acfr_pkg::alu_req_t alu_req;
    acfr_pkg::alu_rsp_t alu_rsp;

    logic             in_fire;
    logic [2:0]       data_idx;
    logic [2:0]       modulus;
    logic [2:0]       offset;
    logic [5:0]       low_addr;
    logic [5:0]       rem_step;

    // Assertion helpers
    logic             frame_close;
    logic             mod_emit;

    acfr_frame_buf u_frame_buf
    (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (byte_count_reg),
        .wr_data (in_data.rx_byte),
        .rd_addr (cnt_reg),
        .rd_data (buf_rd_data)
    );

    acfr_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign in_ready  = (state_reg == acfr_pkg::ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign data_idx = 3'(cnt_reg - 3'd1);
    assign modulus  = target_reg[2:0];
    assign offset   = target_reg[5:3];
    assign low_addr = target_reg[5:0];
    // Keep the trial difference only when it did not borrow
    assign rem_step = alu_rsp.carry ? rem_reg : alu_rsp.value[5:0];

    assign frame_close = in_fire && !in_data.func && receiving_reg &&
                         (byte_count_reg == 3'(acfr_pkg::FRAME_LEN));
    assign mod_emit    = (state_reg == acfr_pkg::ST_EMIT) &&
                         (target_reg[7:6] == acfr_pkg::MODE_RESIDUE);

    always_comb
    begin
        state_next        = state_reg;
        receiving_next    = receiving_reg;
        byte_count_next   = byte_count_reg;
        gap_next          = gap_reg;
        last_session_next = last_session_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg;
        checksum_next     = checksum_reg;
        sum_next          = sum_reg;
        session_next      = session_reg;
        target_next       = target_reg;
        command_next      = command_reg;
        p1_next           = p1_reg;
        p2_next           = p2_reg;
        p3_next           = p3_reg;
        rem_next          = rem_reg;
        pass_next         = pass_reg;
        out_next          = out_reg;
        buf_wr_en         = 1'b0;
        alu_req.op        = acfr_pkg::ALU_ADD;
        alu_req.a         = {1'b0, sum_reg};
        alu_req.b         = {1'b0, buf_rd_data};

        // Drop the result beat once the consumer takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            acfr_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_data.func)
                    begin
                        // Tick: count the gap down, abandon the frame at zero
                        if (gap_reg != 8'd0)
                        begin
                            gap_next = 8'(gap_reg - 8'd1);
                            if (gap_reg == 8'd1)
                            begin
                                receiving_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        gap_next = gap_timeout_reg;
                        if (!receiving_reg)
                        begin
                            byte_count_next = 3'd0;
                            if (in_data.rx_byte == acfr_pkg::SYNC_BYTE)
                            begin
                                receiving_next = 1'b1;
                            end
                        end
                        else if (byte_count_reg < 3'(acfr_pkg::FRAME_LEN))
                        begin
                            buf_wr_en       = 1'b1;
                            byte_count_next = 3'(byte_count_reg + 3'd1);
                        end
                        else
                        begin
                            // Checksum byte: close the frame and start the sum pass
                            checksum_next   = in_data.rx_byte;
                            byte_count_next = 3'd0;
                            receiving_next  = 1'b0;
                            sum_next        = 8'd0;
                            cnt_next        = 3'd0;
                            state_next      = acfr_pkg::ST_SUM;
                        end
                    end
                end
            end

            acfr_pkg::ST_SUM:
            begin
                // Read data lags the address through the registered read port
                if (cnt_reg != 3'd0)
                begin
                    sum_next = alu_rsp.value[7:0];
                    case (data_idx)
                        3'd0:    session_next = buf_rd_data;
                        3'd1:    target_next  = buf_rd_data;
                        3'd2:    command_next = buf_rd_data;
                        3'd3:    p1_next      = buf_rd_data;
                        3'd4:    p2_next      = buf_rd_data;
                        default: p3_next      = buf_rd_data;
                    endcase
                end
                if (cnt_reg == 3'(acfr_pkg::FRAME_LEN))
                begin
                    state_next = acfr_pkg::ST_CHECK;
                end
                else
                begin
                    cnt_next = 3'(cnt_reg + 3'd1);
                end
            end

            acfr_pkg::ST_CHECK:
            begin
                state_next = acfr_pkg::ST_IDLE;
                if ((sum_reg == checksum_reg) && (session_reg != last_session_reg))
                begin
                    last_session_next = session_reg;
                    case (target_reg[7:6])
                        acfr_pkg::MODE_RESIDUE:
                        begin
                            // Zero modulus drops the frame
                            if (modulus != 3'd0)
                            begin
                                rem_next   = dev_addr_reg;
                                cnt_next   = 3'(acfr_pkg::MOD_STEPS - 1);
                                state_next = acfr_pkg::ST_MOD;
                            end
                        end
                        acfr_pkg::MODE_SKIP_ADDRESS:
                        begin
                            pass_next  = (dev_addr_reg != low_addr);
                            state_next = acfr_pkg::ST_EMIT;
                        end
                        acfr_pkg::MODE_ADDRESS:
                        begin
                            pass_next  = (dev_addr_reg == low_addr) ||
                                         (low_addr == acfr_pkg::BROADCAST);
                            state_next = acfr_pkg::ST_EMIT;
                        end
                        default:
                        begin
                            pass_next  = 1'b1;
                            state_next = acfr_pkg::ST_EMIT;
                        end
                    endcase
                end
            end

            acfr_pkg::ST_MOD:
            begin
                // Restoring remainder: subtract modulus shifted by the step index
                alu_req.op = acfr_pkg::ALU_SUB;
                alu_req.a  = {3'b000, rem_reg};
                alu_req.b  = 9'({6'b000000, modulus} << cnt_reg);
                rem_next   = rem_step;
                if (cnt_reg == 3'd0)
                begin
                    pass_next  = (rem_step == {3'b000, offset});
                    state_next = acfr_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = 3'(cnt_reg - 3'd1);
                end
            end

            acfr_pkg::ST_EMIT:
            begin
                if (!pass_reg)
                begin
                    state_next = acfr_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_next.background   = command_reg[7];
                    out_next.animation_id = command_reg[6:0];
                    out_next.param_one    = p1_reg;
                    out_next.param_two    = p2_reg;
                    out_next.param_three  = p3_reg;
                    out_valid_next        = 1'b1;
                    state_next            = acfr_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = acfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= acfr_pkg::ST_IDLE;
            receiving_reg    <= 1'b0;
            byte_count_reg   <= 3'd0;
            gap_reg          <= 8'd0;
            last_session_reg <= 8'd0;
            dev_addr_reg     <= 6'd0;
            gap_timeout_reg  <= acfr_pkg::GAP_TIMEOUT_RESET;
            cnt_reg          <= 3'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            receiving_reg    <= receiving_next;
            byte_count_reg   <= byte_count_next;
            gap_reg          <= gap_next;
            last_session_reg <= last_session_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
            // Configuration beats; indexes past the list are ignored
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    acfr_pkg::CFG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_data[5:0];
                    acfr_pkg::CFG_GAP_TIMEOUT:    gap_timeout_reg <= cfg_data;
                    default:                      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        checksum_reg <= checksum_next;
        sum_reg      <= sum_next;
        session_reg  <= session_next;
        target_reg   <= target_next;
        command_reg  <= command_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        p3_reg       <= p3_next;
        rem_reg      <= rem_next;
        pass_reg     <= pass_next;
        out_reg      <= out_next;
    end

    // Assertions
    `ACFR_ASSERT(a_byte_count_range, byte_count_reg <= 3'(acfr_pkg::FRAME_LEN))
    `ACFR_ASSERT_NEXT(a_checksum_starts_sum, frame_close, (state_reg == acfr_pkg::ST_SUM) && !receiving_reg)
    `ACFR_ASSERT(a_result_from_emit, $rose(out_valid_reg) |-> ($past(state_reg) == acfr_pkg::ST_EMIT))
    `ACFR_ASSERT(a_mod_remainder_below_modulus, mod_emit |-> (rem_reg < {3'b000, modulus}))

endmodule
